// ===== hdl/mlfd_pkg.sv =====
// Package: shared types, constants and segment decode for the meter LCD frame decoder.
package mlfd_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned STORE_BYTES = FRAME_BYTES - 1;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] SEG_MASK   = 8'hF7;
  localparam logic [7:0] CHECK_ADD  = 8'd57;
  localparam logic [7:0] MODE_MAX   = 8'd25;
  localparam logic [3:0] DIGIT_NONE = 4'd10;

  localparam logic [7:0] OL_ONES     = 8'h00;
  localparam logic [7:0] OL_TENS     = 8'h27;
  localparam logic [7:0] OL_HUNDREDS = 8'hD7;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hD7, 8'h50, 8'hB5, 8'hF1, 8'h72, 8'hE3, 8'hE7, 8'h51, 8'hF7, 8'hF3
  };

  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_MODE     = 4'd1,
    ERR_MISMATCH = 4'd2,
    ERR_UNITS    = 4'd3,
    ERR_MULT     = 4'd4,
    ERR_MINMAX   = 4'd5,
    ERR_POINTS   = 4'd6,
    ERR_RS232    = 4'd7,
    ERR_CHECKSUM = 4'd8
  } err_e;

  typedef enum logic [2:0] {
    UNIT_F       = 3'd0,
    UNIT_OHM     = 3'd1,
    UNIT_A       = 3'd2,
    UNIT_HZ      = 3'd3,
    UNIT_V       = 3'd4,
    UNIT_PERCENT = 3'd5,
    UNIT_UNKNOWN = 3'd6
  } unit_e;

  typedef enum logic [2:0] {
    PRE_NONE  = 3'd0,
    PRE_NANO  = 3'd1,
    PRE_MICRO = 3'd2,
    PRE_MILLI = 3'd3,
    PRE_KILO  = 3'd4,
    PRE_MEGA  = 3'd5
  } prefix_e;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic        frame_ok;
    err_e        error_code;
    logic [3:0]  digit_thousands;
    logic [3:0]  digit_hundreds;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_ones;
    logic        negative;
    logic [1:0]  decimal_position;
    logic        overload;
    unit_e       unit_code;
    prefix_e     prefix_code;
    logic        ac_mode;
  } result_t;

  function automatic logic [3:0] seg_to_digit(input logic [7:0] b);
    logic [7:0] m;
    logic [3:0] d;
    m = b & SEG_MASK;
    d = DIGIT_NONE;
    for (int n = 9; n >= 0; n--) begin
      if (m == SEG_TABLE[n]) d = 4'(n);
    end
    return d;
  endfunction

endpackage

// ===== hdl/mlfd_collect.sv =====
// Byte collector: frame byte counter, byte store and the registered full frame.
module mlfd_collect import mlfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_start_i,
  input  logic       adv_i,
  output logic       frame_valid_o,
  output frame_t     frame_o
);

  logic [IDX_W-1:0] byte_index_q, byte_index_d;
  logic [IDX_W-1:0] idx_eff;
  logic [7:0]       store_q [STORE_BYTES];
  logic             last_byte;
  logic             frame_valid_q, frame_valid_d;
  frame_t           frame_q, frame_d;

  assign idx_eff   = frame_start_i ? '0 : byte_index_q;
  assign last_byte = (idx_eff == IDX_W'(STORE_BYTES));

  always_comb begin
    byte_index_d  = byte_index_q;
    frame_valid_d = frame_valid_q;
    for (int i = 0; i < STORE_BYTES; i++) begin
      frame_d[i] = store_q[i];
    end
    frame_d[STORE_BYTES] = frame_byte_i;
    if (adv_i) begin
      frame_valid_d = 1'b0;
    end
    if (in_fire_i) begin
      if (last_byte) begin
        byte_index_d  = '0;
        frame_valid_d = 1'b1;
      end else begin
        byte_index_d = idx_eff + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      byte_index_q  <= byte_index_d;
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && !last_byte) begin
      store_q[idx_eff[$clog2(STORE_BYTES)-1:0]] <= frame_byte_i;
    end
    if (in_fire_i && last_byte) begin
      frame_q <= frame_d;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= IDX_W'(STORE_BYTES))
    else $error("byte index past frame end");

  a_frame_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && last_byte) |=> (frame_valid_q && byte_index_q == '0))
    else $error("ninth byte did not load a frame");

  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_q && !adv_i) |=> frame_valid_q)
    else $error("frame dropped before it was passed on");

endmodule

// ===== hdl/mlfd_check.sv =====
// Frame checker and display decoder: one full frame in, one result out.
module mlfd_check import mlfd_pkg::*; (
  input  frame_t  frame_i,
  output result_t result_o
);

  logic [7:0] mode, b1, b2, sum;
  logic [3:0] unit1, unit_all;
  logic [2:0] mult1, mult_all, minmax2, minmax6, dp;
  logic       mode_bad, mis1, req_bad, mis2;
  err_e       err;

  assign mode = frame_i[0];
  assign b1   = frame_i[1];
  assign b2   = frame_i[2];

  assign mode_bad = mode > MODE_MAX;

  assign mis1 =
    (b1[1] && mode != 8'd0 && mode != 8'd1 && mode != 8'd19 && mode != 8'd22) ||
    (b1[2] && (mode < 8'd2 || mode > 8'd7)) ||
    (b1[3] && mode != 8'd9) ||
    (b1[6] && mode != 8'd8) ||
    (b1[7] && (mode < 8'd10 || mode > 8'd12));

  assign unit1 = 4'(b1[1]) + 4'(b1[2]) + 4'(b1[3]) + 4'(b1[6]) + 4'(b1[7]);
  assign mult1 = 3'(b1[0]) + 3'(b1[4]) + 3'(b1[5]);

  always_comb begin
    priority if (mode < 8'd2)  req_bad = !b1[1];
    else if (mode < 8'd8)      req_bad = !b1[2];
    else if (mode < 8'd9)      req_bad = !b1[6];
    else if (mode < 8'd10)     req_bad = !b1[3];
    else if (mode < 8'd13)     req_bad = !b1[7];
    else                       req_bad = 1'b0;
  end

  assign mis2 =
    (b2[2] && mode != 8'd21) ||
    (b2[4] && (mode < 8'd16 || mode > 8'd18)) ||
    (b2[5] && mode != 8'd23);

  assign unit_all = unit1 + 4'(b2[2]) + 4'(b2[4]) + 4'(b2[5]);
  assign mult_all = mult1 + 3'(b2[6]) + 3'(b2[7]);
  assign minmax2  = 3'(b2[0]) + 3'(b2[1]);
  assign minmax6  = minmax2 + 3'(frame_i[6][3]);
  assign dp       = 3'(frame_i[3][3]) + 3'(frame_i[4][3]) + 3'(frame_i[5][3]);

  always_comb begin
    sum = CHECK_ADD;
    for (int i = 0; i < STORE_BYTES; i++) begin
      sum = sum + frame_i[i];
    end
  end

  always_comb begin
    priority if (mode_bad)                  err = ERR_MODE;
    else if (mis1)                          err = ERR_MISMATCH;
    else if (unit1 > 4'd1)                  err = ERR_UNITS;
    else if (mult1 > 3'd1)                  err = ERR_MULT;
    else if (req_bad || mis2)               err = ERR_MISMATCH;
    else if (unit_all > 4'd1)               err = ERR_UNITS;
    else if (mult_all > 3'd1)               err = ERR_MULT;
    else if (minmax2 > 3'd1)                err = ERR_MINMAX;
    else if (dp > 3'd1)                     err = ERR_POINTS;
    else if (minmax6 > 3'd1)                err = ERR_MINMAX;
    else if (!frame_i[7][1])                err = ERR_RS232;
    else if (sum != frame_i[STORE_BYTES])   err = ERR_CHECKSUM;
    else                                    err = ERR_OK;
  end

  always_comb begin
    result_o.frame_ok        = (err == ERR_OK);
    result_o.error_code      = err;
    result_o.digit_thousands = seg_to_digit(frame_i[6]);
    result_o.digit_hundreds  = seg_to_digit(frame_i[5]);
    result_o.digit_tens      = seg_to_digit(frame_i[4]);
    result_o.digit_ones      = seg_to_digit(frame_i[3]);
    result_o.negative        = frame_i[7][3];
    result_o.ac_mode         = frame_i[7][2];
    result_o.overload        = ((frame_i[3] & SEG_MASK) == OL_ONES) &&
                               ((frame_i[4] & SEG_MASK) == OL_TENS) &&
                               ((frame_i[5] & SEG_MASK) == OL_HUNDREDS);

    priority if (frame_i[3][3]) result_o.decimal_position = 2'd3;
    else if (frame_i[4][3])     result_o.decimal_position = 2'd2;
    else if (frame_i[5][3])     result_o.decimal_position = 2'd1;
    else                        result_o.decimal_position = 2'd0;

    priority if (b1[3]) result_o.unit_code = UNIT_F;
    else if (b1[6])     result_o.unit_code = UNIT_OHM;
    else if (b1[2])     result_o.unit_code = UNIT_A;
    else if (b1[7])     result_o.unit_code = UNIT_HZ;
    else if (b1[1])     result_o.unit_code = UNIT_V;
    else if (b2[7])     result_o.unit_code = UNIT_PERCENT;
    else                result_o.unit_code = UNIT_UNKNOWN;

    priority if (b2[6]) result_o.prefix_code = PRE_NANO;
    else if (b2[7])     result_o.prefix_code = PRE_MICRO;
    else if (b1[0])     result_o.prefix_code = PRE_MILLI;
    else if (b1[5])     result_o.prefix_code = PRE_KILO;
    else if (b1[4])     result_o.prefix_code = PRE_MEGA;
    else                result_o.prefix_code = PRE_NONE;
  end

endmodule

// ===== hdl/multimeter_lcd_frame_decoder.sv =====
// Top level: meter LCD frame decoder with byte input and one result per frame.
//
// Input channel (in_valid_i/in_ready_o) carries one frame byte per item with
// frame_start_i marking byte 0; a start drops any partial frame. Every ninth
// byte of a frame completes it and yields one result item on the output
// channel (out_valid_o/out_ready_i); other bytes yield nothing.
// Throughput: one byte per cycle, sustained, while results are taken.
// The edge that accepts the ninth byte loads the frame register; the result
// register then loads from the check and decode logic once the output
// channel is free.
// The frame register and the result register form a two-deep pipeline; when
// the receiver stalls, the result holds and the frame register stays full,
// and in_ready_o drops only once both are occupied.
// Reset clears the byte counter and both valid flags; the byte store is not
// cleared, since every frame writes bytes 0 to 7 before its check byte.
module multimeter_lcd_frame_decoder import mlfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_ok_o,
  output logic [3:0] error_code_o,
  output logic [3:0] digit_thousands_o,
  output logic [3:0] digit_hundreds_o,
  output logic [3:0] digit_tens_o,
  output logic [3:0] digit_ones_o,
  output logic       negative_o,
  output logic [1:0] decimal_position_o,
  output logic       overload_o,
  output logic [2:0] unit_code_o,
  output logic [2:0] prefix_code_o,
  output logic       ac_mode_o
);

  logic    out_free, frame_valid, adv, in_fire;
  logic    out_valid_q;
  frame_t  frame;
  result_t res, res_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = frame_valid && out_free;
  assign in_ready_o = !frame_valid || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  mlfd_collect u_collect (
    .clk_i,
    .rst_ni,
    .in_fire_i     (in_fire),
    .frame_byte_i,
    .frame_start_i,
    .adv_i         (adv),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  mlfd_check u_check (
    .frame_i  (frame),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= frame_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_ok_o         = res_q.frame_ok;
  assign error_code_o       = res_q.error_code;
  assign digit_thousands_o  = res_q.digit_thousands;
  assign digit_hundreds_o   = res_q.digit_hundreds;
  assign digit_tens_o       = res_q.digit_tens;
  assign digit_ones_o       = res_q.digit_ones;
  assign negative_o         = res_q.negative;
  assign decimal_position_o = res_q.decimal_position;
  assign overload_o         = res_q.overload;
  assign unit_code_o        = res_q.unit_code;
  assign prefix_code_o      = res_q.prefix_code;
  assign ac_mode_o          = res_q.ac_mode;

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.frame_ok == (res_q.error_code == ERR_OK)))
    else $error("frame_ok disagrees with error code");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted with pipeline full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("result changed while stalled");

endmodule
